/* hdl/tclw_pkg.sv */
// shared types and constants of the tile cache
package tclw_pkg;

    localparam int ENTRIES  = 64;
    localparam int AGE_BITS = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W   = 6;
    localparam int HANDLE_W = 16;
    localparam int TYPE_W   = 3;
    localparam int ZOOM_W   = 5;
    localparam int COORD_W  = 24;

    typedef struct packed {
        logic [TYPE_W-1:0]  map_type;
        logic [ZOOM_W-1:0]  zoom;
        logic [COORD_W-1:0] tile_x;
        logic [COORD_W-1:0] tile_y;
    } key_t;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
        key_t                key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // write broadcast from the control to every cell
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic                touch;
        logic [AGE_BITS-1:0] age;
        logic                fill;
        key_t                key;
        logic [HANDLE_W-1:0] handle;
        logic                dirty;
        logic                clr_dirty;
    } wr_t;

    // search results gathered over one pass around the ring
    typedef struct packed {
        logic                match_found;
        logic [IDX_W-1:0]    match_idx;
        logic [HANDLE_W-1:0] match_handle;
        logic                free_found;
        logic [IDX_W-1:0]    free_idx;
        logic [AGE_BITS-1:0] min_age;
        logic [IDX_W-1:0]    min_idx;
        logic                dirty_found;
        logic [IDX_W-1:0]    dirty_idx;
        key_t                dirty_key;
        logic [HANDLE_W-1:0] dirty_handle;
    } scan_t;

endpackage

/* hdl/tile_cache_lru_writeback.sv */
// tile cache top level: control, configuration, entry ring and result register
//
//  channel  | dir | handshake           | payload
//  s_       | in  | s_valid / s_ready   | cmd, key, handle, already_stored
//  m_       | out | m_valid / m_ready   | hit, slot, handle, flush key
//  apb      | in  | psel penable pready | flush_enable at address 0
//
//  each transfer captures the input, then makes one pass of the entry ring past
//  the search unit, then writes back in the commit state
//  the next transfer is taken once the result is in the output register
//  a stalled result holds the write-back cycle until the register frees
//  reset clears valid, dirty and age bits of all entries
module tile_cache_lru_writeback (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [2:0]  s_map_type,
    input  logic [4:0]  s_zoom,
    input  logic [23:0] s_tile_x,
    input  logic [23:0] s_tile_y,
    input  logic [15:0] s_tile_handle,
    input  logic        s_already_stored,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [5:0]  m_slot,
    output logic [15:0] m_out_handle,
    output logic        m_flush_valid,
    output logic [2:0]  m_flush_type,
    output logic [4:0]  m_flush_zoom,
    output logic [23:0] m_flush_x,
    output logic [23:0] m_flush_y
);
    import tclw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic       REG_FLUSH_ENABLE = 1'b0;
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                flush_en_reg;
    logic [AGE_BITS-1:0] clock_reg, clock_next;
    logic [1:0]          cmd_reg;
    key_t                key_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                stored_reg;

    logic                m_valid_reg, m_valid_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [HANDLE_W-1:0] oh_reg, oh_next;
    logic                fv_reg, fv_next;
    key_t                fkey_reg, fkey_next;

    entry_t              ring [ENTRIES];
    wr_t                 wr;
    scan_t               res;
    logic                accept, commit, shift, do_touch;
    logic [IDX_W-1:0]    ins_idx;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FLUSH_ENABLE) ? {31'b0, flush_en_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_en_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_FLUSH_ENABLE)) begin
            flush_en_reg <= pwdata[0];
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign shift   = (state_reg == ST_SCAN);
    assign commit  = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);

    // entry ring, data moves toward cell 0 so cell 0 shows entry cnt
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        tclw_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (shift),
            .my_idx  (IDX_W'(i)),
            .e_in    (ring[(i + 1) % ENTRIES]),
            .wr      (wr),
            .e_out   (ring[i])
        );
    end

    tclw_scan u_scan (
        .aclk   (aclk),
        .start  (accept),
        .step   (shift),
        .idx    (cnt_reg),
        .e_head (ring[0]),
        .key    (key_reg),
        .res    (res)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg           <= s_cmd;
            key_reg.map_type  <= s_map_type;
            key_reg.zoom      <= s_zoom;
            key_reg.tile_x    <= s_tile_x;
            key_reg.tile_y    <= s_tile_y;
            handle_reg        <= s_tile_handle;
            stored_reg        <= s_already_stored;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // write-back decision and result
    always_comb begin
        priority if (res.match_found) begin
            ins_idx = res.match_idx;
        end else if (res.free_found) begin
            ins_idx = res.free_idx;
        end else begin
            ins_idx = res.min_idx;
        end
    end

    always_comb begin
        wr           = '0;
        wr.age       = clock_reg;
        wr.key       = key_reg;
        wr.handle    = handle_reg;
        wr.dirty     = !stored_reg;
        do_touch     = 1'b0;
        hit_next     = 1'b0;
        slot_next    = '0;
        oh_next      = '0;
        fv_next      = 1'b0;
        fkey_next    = '0;
        unique case (cmd_reg)
            CMD_LOOKUP: begin
                if (res.match_found) begin
                    do_touch  = 1'b1;
                    wr.idx    = res.match_idx;
                    wr.touch  = 1'b1;
                    hit_next  = 1'b1;
                    slot_next = SLOT_W'(res.match_idx);
                    oh_next   = res.match_handle;
                end
            end
            CMD_INSERT: begin
                do_touch  = 1'b1;
                wr.idx    = ins_idx;
                wr.touch  = 1'b1;
                wr.fill   = 1'b1;
                slot_next = SLOT_W'(ins_idx);
            end
            CMD_FLUSH: begin
                if (flush_en_reg && res.dirty_found) begin
                    wr.idx       = res.dirty_idx;
                    wr.clr_dirty = 1'b1;
                    slot_next    = SLOT_W'(res.dirty_idx);
                    oh_next      = res.dirty_handle;
                    fv_next      = 1'b1;
                    fkey_next    = res.dirty_key;
                end
            end
            default: begin
            end
        endcase
        wr.en = commit && (do_touch || wr.clr_dirty);
    end

    always_comb begin
        clock_next = clock_reg;
        if (commit && do_touch && (clock_reg != AGE_MAX)) begin
            clock_next = clock_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            clock_reg   <= AGE_BITS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clock_reg   <= clock_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            hit_reg  <= hit_next;
            slot_reg <= slot_next;
            oh_reg   <= oh_next;
            fv_reg   <= fv_next;
            fkey_reg <= fkey_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = hit_reg;
    assign m_slot        = slot_reg;
    assign m_out_handle  = oh_reg;
    assign m_flush_valid = fv_reg;
    assign m_flush_type  = fkey_reg.map_type;
    assign m_flush_zoom  = fkey_reg.zoom;
    assign m_flush_x     = fkey_reg.tile_x;
    assign m_flush_y     = fkey_reg.tile_y;

endmodule

/* hdl/tclw_cell.sv */
// one cache entry of the rotating ring
module tclw_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift,
    input  logic [tclw_pkg::IDX_W-1:0] my_idx,
    input  tclw_pkg::entry_t       e_in,
    input  tclw_pkg::wr_t          wr,
    output tclw_pkg::entry_t       e_out
);
    import tclw_pkg::*;

    logic                valid_reg, valid_next;
    logic                dirty_reg, dirty_next;
    logic [AGE_BITS-1:0] age_reg, age_next;
    key_t                key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic                sel;

    assign sel = wr.en && (wr.idx == my_idx);

    always_comb begin
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        age_next    = age_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        if (shift) begin
            valid_next  = e_in.valid;
            dirty_next  = e_in.dirty;
            age_next    = e_in.age;
            key_next    = e_in.key;
            handle_next = e_in.handle;
        end else if (sel) begin
            if (wr.touch) begin
                age_next = wr.age;
            end
            if (wr.fill) begin
                valid_next  = 1'b1;
                key_next    = wr.key;
                handle_next = wr.handle;
                dirty_next  = wr.dirty;
            end
            if (wr.clr_dirty) begin
                dirty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            age_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    always_comb begin
        e_out.valid  = valid_reg;
        e_out.dirty  = dirty_reg;
        e_out.age    = age_reg;
        e_out.key    = key_reg;
        e_out.handle = handle_reg;
    end

endmodule

/* hdl/tclw_scan.sv */
// search unit at the head of the ring, one entry per cycle while step is high
module tclw_scan (
    input  logic                       aclk,
    input  logic                       start,
    input  logic                       step,
    input  logic [tclw_pkg::IDX_W-1:0] idx,
    input  tclw_pkg::entry_t           e_head,
    input  tclw_pkg::key_t             key,
    output tclw_pkg::scan_t            res
);
    import tclw_pkg::*;

    scan_t res_reg, res_next;

    always_comb begin
        res_next = res_reg;
        if (start) begin
            res_next = '0;
        end else if (step) begin
            if (!res_reg.match_found && e_head.valid && (e_head.key == key)) begin
                res_next.match_found  = 1'b1;
                res_next.match_idx    = idx;
                res_next.match_handle = e_head.handle;
            end
            if (!res_reg.free_found && !e_head.valid) begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = idx;
            end
            if ((idx == '0) || (e_head.age < res_reg.min_age)) begin
                res_next.min_age = e_head.age;
                res_next.min_idx = idx;
            end
            if (!res_reg.dirty_found && e_head.valid && e_head.dirty) begin
                res_next.dirty_found  = 1'b1;
                res_next.dirty_idx    = idx;
                res_next.dirty_key    = e_head.key;
                res_next.dirty_handle = e_head.handle;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

/* bench/tile_cache_lru_writeback_tb.sv */
// self-checking testbench of the tile cache with lru replacement and dirty write-back
module tile_cache_lru_writeback_tb;
    import tclw_pkg::*;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_e;

    localparam logic [2:0] REG_FLUSH_ENABLE = 3'd0;
    localparam int POOL_SIZE = 96;
    localparam int DRAIN_CYCLES = ENTRIES + 16;

    typedef struct packed {
        cmd_e                cmd;
        key_t                key;
        logic [HANDLE_W-1:0] handle;
        logic                stored;
    } tile_req_t;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic                flush_valid;
        key_t                flush_key;
    } tile_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [2:0]  s_map_type = '0;
    logic [4:0]  s_zoom = '0;
    logic [23:0] s_tile_x = '0;
    logic [23:0] s_tile_y = '0;
    logic [15:0] s_tile_handle = '0;
    logic        s_already_stored = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;
    logic [5:0]  m_slot;
    logic [15:0] m_out_handle;
    logic        m_flush_valid;
    logic [2:0]  m_flush_type;
    logic [4:0]  m_flush_zoom;
    logic [23:0] m_flush_x;
    logic [23:0] m_flush_y;

    // predicted cache contents
    logic                cache_valid [ENTRIES] = '{default: 1'b0};
    key_t                cache_key [ENTRIES];
    logic [HANDLE_W-1:0] cache_handle [ENTRIES];
    logic [AGE_BITS-1:0] cache_age [ENTRIES] = '{default: '0};
    logic                cache_dirty [ENTRIES] = '{default: 1'b0};
    logic [AGE_BITS-1:0] stamp_clock = 1;
    logic                flush_on = 1'b0;

    tile_req_t    pending_reqs[$];
    tile_result_t expected_results[$];
    tile_req_t    drive_req;
    tile_result_t want_result;
    key_t         key_pool [POOL_SIZE];
    bit           req_taken = 1'b0;
    bit           calm = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           items_sent = 0;
    int           results_checked = 0;
    int           mismatch_count = 0;

    tile_cache_lru_writeback u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_map_type       (s_map_type),
        .s_zoom           (s_zoom),
        .s_tile_x         (s_tile_x),
        .s_tile_y         (s_tile_y),
        .s_tile_handle    (s_tile_handle),
        .s_already_stored (s_already_stored),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_out_handle     (m_out_handle),
        .m_flush_valid    (m_flush_valid),
        .m_flush_type     (m_flush_type),
        .m_flush_zoom     (m_flush_zoom),
        .m_flush_x        (m_flush_x),
        .m_flush_y        (m_flush_y)
    );

    always #1 aclk = ~aclk;

    function automatic int find_tile(key_t key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i] && cache_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void stamp_entry(int idx);
        cache_age[idx] = stamp_clock;
        if (stamp_clock != '1) begin
            stamp_clock = stamp_clock + 1'b1;
        end
    endfunction

    function automatic tile_result_t cache_predict(tile_req_t req);
        tile_result_t res;
        int           sel;
        res = '0;
        sel = -1;
        case (req.cmd)
            CMD_LOOKUP: begin
                sel = find_tile(req.key);
                if (sel >= 0) begin
                    stamp_entry(sel);
                    res.hit = 1'b1;
                    res.slot = sel[SLOT_W-1:0];
                    res.handle = cache_handle[sel];
                end
            end
            CMD_INSERT: begin
                sel = find_tile(req.key);
                for (int i = 0; i < ENTRIES; i++) begin
                    if (sel < 0 && !cache_valid[i]) begin
                        sel = i;
                    end
                end
                if (sel < 0) begin
                    sel = 0;
                    for (int i = 1; i < ENTRIES; i++) begin
                        if (cache_age[i] < cache_age[sel]) begin
                            sel = i;
                        end
                    end
                end
                stamp_entry(sel);
                cache_valid[sel] = 1'b1;
                cache_key[sel] = req.key;
                cache_handle[sel] = req.handle;
                cache_dirty[sel] = !req.stored;
                res.slot = sel[SLOT_W-1:0];
            end
            CMD_TICK: begin
                if (flush_on) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (sel < 0 && cache_valid[i] && cache_dirty[i]) begin
                            sel = i;
                            cache_dirty[i] = 1'b0;
                            res.slot = i[SLOT_W-1:0];
                            res.handle = cache_handle[i];
                            res.flush_valid = 1'b1;
                            res.flush_key = cache_key[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int pick_idle();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic key_t random_key();
        key_t k;
        k.map_type = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                  : 3'($urandom_range(5, 7));
        k.zoom = 5'($urandom_range(0, 31));
        k.tile_x = 24'($urandom_range(0, 24'hFFFFFF));
        k.tile_y = 24'($urandom_range(0, 24'hFFFFFF));
        return k;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_req(cmd_e c, key_t k, logic [HANDLE_W-1:0] h, logic st);
        tile_req_t r;
        r.cmd = c;
        r.key = k;
        r.handle = h;
        r.stored = st;
        pending_reqs.push_back(r);
        items_sent++;
    endtask

    task automatic queue_random(int count);
        int   r;
        cmd_e c;
        key_t k;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                c = CMD_LOOKUP;
            end else if (r < 75) begin
                c = CMD_INSERT;
            end else if (r < 95) begin
                c = CMD_TICK;
            end else begin
                c = CMD_NOP;
            end
            if ($urandom_range(0, 99) < 88) begin
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                k = random_key();
            end
            queue_req(c, k, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (results_checked != items_sent) begin
            @(negedge aclk);
        end
    endtask

    // write the flush enable, then read it back
    task automatic set_flush(logic value);
        logic [31:0] rd;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_FLUSH_ENABLE;
        pwdata <= {31'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        flush_on = value;
        check_field("prdata", {31'd0, value}, rd);
    endtask

    // input side driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                drive_req = pending_reqs.pop_front();
                s_cmd <= drive_req.cmd;
                s_map_type <= drive_req.key.map_type;
                s_zoom <= drive_req.key.zoom;
                s_tile_x <= drive_req.key.tile_x;
                s_tile_y <= drive_req.key.tile_y;
                s_tile_handle <= drive_req.handle;
                s_already_stored <= drive_req.stored;
                s_valid <= 1'b1;
                send_gap = pick_idle();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = pick_idle();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // transfer monitor on both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(cache_predict(drive_req));
            req_taken = 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no pending expectation");
                mismatch_count++;
            end else begin
                want_result = expected_results.pop_front();
                check_field("hit", want_result.hit, m_hit);
                check_field("slot", want_result.slot, m_slot);
                check_field("out_handle", want_result.handle, m_out_handle);
                check_field("flush_valid", want_result.flush_valid, m_flush_valid);
                check_field("flush_type", want_result.flush_key.map_type, m_flush_type);
                check_field("flush_zoom", want_result.flush_key.zoom, m_flush_zoom);
                check_field("flush_x", want_result.flush_key.tile_x, m_flush_x);
                check_field("flush_y", want_result.flush_key.tile_y, m_flush_y);
                results_checked++;
            end
        end
    end

    initial begin
        key_t key_lo;
        key_t key_hi;
        key_t key_odd;
        key_t key_near;
        key_t k;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < POOL_SIZE / 2) begin
                key_pool[i] = random_key();
            end else begin
                // near neighbors differ from an earlier key in one bit
                k = key_pool[i - POOL_SIZE / 2];
                case ($urandom_range(0, 3))
                    0: k.map_type = k.map_type ^ (3'd1 << $urandom_range(0, 2));
                    1: k.zoom = k.zoom ^ (5'd1 << $urandom_range(0, 4));
                    2: k.tile_x = k.tile_x ^ (24'd1 << $urandom_range(0, 23));
                    default: k.tile_y = k.tile_y ^ (24'd1 << $urandom_range(0, 23));
                endcase
                key_pool[i] = k;
            end
        end
        key_lo = '0;
        key_hi = '{map_type: 3'd4, zoom: 5'd31, tile_x: 24'hFFFFFF, tile_y: 24'hFFFFFF};
        key_odd = '{map_type: 3'd7, zoom: 5'd21, tile_x: 24'hA5A5A5, tile_y: 24'h5A5A5A};
        key_near = key_lo;
        key_near.tile_y = 24'd1;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed, flushing off
        set_flush(1'b0);
        queue_req(CMD_LOOKUP, key_lo, 16'h0000, 1'b0);
        queue_req(CMD_INSERT, key_lo, 16'h0000, 1'b0);
        queue_req(CMD_INSERT, key_hi, 16'hFFFF, 1'b1);
        queue_req(CMD_INSERT, key_odd, 16'h1234, 1'b0);
        queue_req(CMD_LOOKUP, key_hi, 16'h0000, 1'b0);
        queue_req(CMD_LOOKUP, key_near, 16'hFFFF, 1'b1);
        queue_req(CMD_LOOKUP, key_odd, 16'h0000, 1'b0);
        queue_req(CMD_INSERT, key_lo, 16'hBEEF, 1'b0);
        queue_req(CMD_TICK, key_hi, 16'hFFFF, 1'b1);
        queue_req(CMD_NOP, key_hi, 16'hFFFF, 1'b1);
        wait_drained();

        // directed write-back, then random with gaps
        set_flush(1'b1);
        queue_req(CMD_TICK, key_lo, 16'h0000, 1'b0);
        queue_req(CMD_TICK, key_lo, 16'h0000, 1'b0);
        queue_req(CMD_TICK, key_lo, 16'h0000, 1'b0);
        queue_req(CMD_INSERT, key_hi, 16'h0F0F, 1'b0);
        queue_req(CMD_TICK, key_odd, 16'h0000, 1'b0);
        queue_req(CMD_LOOKUP, key_lo, 16'h0000, 1'b0);
        queue_random(450);
        wait_drained();

        // back to back transfers, flushing off
        calm = 1'b1;
        set_flush(1'b0);
        queue_random(300);
        wait_drained();
        calm = 1'b0;

        set_flush(1'b1);
        queue_random(350);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tclw_pkg.sv
hdl/tclw_cell.sv
hdl/tclw_scan.sv
hdl/tile_cache_lru_writeback.sv
bench/tile_cache_lru_writeback_tb.sv
